### hw/rtl/spin_lidar_point_time_offset_unit_defines.svh
// Assertion macros used by the checker file.
// No dependencies.
`ifndef SPIN_LIDAR_POINT_TIME_OFFSET_UNIT_DEFINES_SVH
`define SPIN_LIDAR_POINT_TIME_OFFSET_UNIT_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define SLT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define SLT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

### hw/rtl/slpto_pkg.sv
// Shared types, constants and the CORDIC angle table for the time offset unit.
// No dependencies.
package slpto_pkg;
    localparam int Rings       = 64;
    localparam int RingW       = 6;
    localparam int CordicSteps = 20;
    localparam int CordicW     = 30;
    localparam int AngW        = 26;
    localparam int OfsW        = 20;
    localparam int QDepth      = 2;
    localparam logic [AngW-1:0] Deg90  = AngW'(90 * 65536);
    localparam logic [AngW-1:0] Deg360 = AngW'(360 * 65536);
    localparam logic [1:0] RegDecim = 2'd0;
    localparam logic [1:0] RegBlind = 2'd1;
    localparam logic [1:0] RegMsDeg = 2'd2;

    typedef struct packed {
        logic                     first;
        logic                     keep;
        logic signed [AngW-1:0]   yaw;
        logic [RingW-1:0]         ring;
        logic signed [24:0]       x;
        logic signed [24:0]       y;
        logic signed [24:0]       z;
        logic [15:0]              intensity;
    } t_work;

    function automatic logic [AngW-1:0] atan_lut(input logic [4:0] i);
        logic [AngW-1:0] v;
        case (i)
            5'd0: v = 26'd2949120;  5'd1: v = 26'd1740967;
            5'd2: v = 26'd919879;   5'd3: v = 26'd466945;
            5'd4: v = 26'd234379;   5'd5: v = 26'd117304;
            5'd6: v = 26'd58666;    5'd7: v = 26'd29335;
            5'd8: v = 26'd14668;    5'd9: v = 26'd7334;
            5'd10: v = 26'd3667;    5'd11: v = 26'd1833;
            5'd12: v = 26'd917;     5'd13: v = 26'd458;
            5'd14: v = 26'd229;     5'd15: v = 26'd115;
            5'd16: v = 26'd57;      5'd17: v = 26'd29;
            5'd18: v = 26'd14;      5'd19: v = 26'd7;
            5'd20: v = 26'd4;       5'd21: v = 26'd2;
            5'd22: v = 26'd1;
            default: v = '0;
        endcase
        return v;
    endfunction
endpackage

### hw/rtl/spin_lidar_point_time_offset_unit.sv
// Top level of the lidar point time offset unit.
// Depends on slpto_pkg, slpto_front, slpto_queue, slpto_back.
//
// Input channel: i_valid/o_ready carry one scan point word (coordinates,
// intensity, ring, first-of-frame). Output channel: o_valid/i_ready carry
// one result word per point: keep flag, time offset and the passed-through
// coordinates and intensity.
// Path: a point passes the setup states S_SQ and S_SUM, 20 CORDIC
// iterations in the front (skipped when x and y are both zero), the queue,
// and the back states S_RD, S_MUL and S_FIN into the output register.
// Throughput is set by the single iterative CORDIC in the front: it takes
// no new point until the last one has left it. The back handles one word at
// a time through its states and runs concurrently behind a two-word queue.
// Reset: clears ring-seen flags, frame phase, all valids; registers return
// to decimation 1, blind distance 0, 18154 ms-per-degree.
// Stall: while i_ready is low the result word holds, the back stops, the
// front fills the queue, then holds its finished word and drops o_ready.
// Config: i_cfg_we/i_cfg_addr/i_cfg_data; write only while idle.
module spin_lidar_point_time_offset_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_addr,
    input  logic [23:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_first_of_frame,
    input  logic signed [24:0] i_pos_x,
    input  logic signed [24:0] i_pos_y,
    input  logic signed [24:0] i_pos_z,
    input  logic [15:0]        i_intensity,
    input  logic [5:0]         i_ring,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_keep,
    output logic [19:0]        o_time_ofs,
    output logic signed [24:0] o_out_x,
    output logic signed [24:0] o_out_y,
    output logic signed [24:0] o_out_z,
    output logic [15:0]        o_out_intensity
);
    import slpto_pkg::*;

    logic [7:0]  r_decim;
    logic [23:0] r_blind;
    logic [15:0] r_msdeg;
    logic  w_f_valid, w_f_ready, w_q_valid, w_q_ready;
    t_work w_f_work, w_q_work;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decim <= 8'd1;
            r_blind <= '0;
            r_msdeg <= 16'd18154;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                RegDecim: r_decim <= i_cfg_data[7:0];
                RegBlind: r_blind <= i_cfg_data;
                RegMsDeg: r_msdeg <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    slpto_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready,
        .i_first_of_frame, .i_pos_x, .i_pos_y, .i_pos_z, .i_intensity, .i_ring,
        .i_decim(r_decim), .i_blind(r_blind),
        .o_valid(w_f_valid), .i_ready(w_f_ready), .o_work(w_f_work)
    );

    slpto_queue u_queue (
        .i_clk, .i_rst_n,
        .i_valid(w_f_valid), .o_ready(w_f_ready), .i_work(w_f_work),
        .o_valid(w_q_valid), .i_ready(w_q_ready), .o_work(w_q_work)
    );

    slpto_back u_back (
        .i_clk, .i_rst_n,
        .i_valid(w_q_valid), .o_ready(w_q_ready), .i_work(w_q_work),
        .i_ms_deg(r_msdeg),
        .o_valid, .i_ready, .o_keep, .o_time_ofs,
        .o_out_x, .o_out_y, .o_out_z, .o_out_intensity
    );
endmodule

### hw/rtl/slpto_front.sv
// Front: accepts points, computes keep, iterates CORDIC yaw one step a cycle.
// Depends on slpto_pkg.
module slpto_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_first_of_frame,
    input  logic signed [24:0]  i_pos_x,
    input  logic signed [24:0]  i_pos_y,
    input  logic signed [24:0]  i_pos_z,
    input  logic [15:0]         i_intensity,
    input  logic [5:0]          i_ring,
    input  logic [7:0]          i_decim,
    input  logic [23:0]         i_blind,
    output logic                o_valid,
    input  logic                i_ready,
    output slpto_pkg::t_work    o_work
);
    import slpto_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001, S_SQ = 4'b0010, S_SUM = 4'b0100, S_ROT = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic [7:0] r_phase;
    logic [4:0] r_step;
    logic signed [CordicW-1:0] r_cx, r_cy;
    logic signed [AngW-1:0] r_cz;
    logic [49:0] r_sx, r_sy, r_sz;
    logic [47:0] r_b2;
    logic r_zero, r_phase0;
    t_work r_work;
    logic [7:0] w_factor, w_phase_in, w_phase_nx;
    logic signed [CordicW-1:0] w_xs, w_ys;
    logic [51:0] w_r2;

    assign w_factor   = (i_decim == 8'd0) ? 8'd1 : i_decim;
    assign w_phase_in = i_first_of_frame ? 8'd0 : r_phase;
    assign w_phase_nx = ((9'(w_phase_in) + 9'd1) >= 9'(w_factor)) ? 8'd0 : w_phase_in + 8'd1;
    assign w_xs = r_cx >>> r_step;
    assign w_ys = r_cy >>> r_step;
    assign w_r2 = 52'(r_sx) + 52'(r_sy) + 52'(r_sz);
    assign o_ready = (r_state == S_IDLE) && !o_valid;
    assign o_work  = r_work;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_valid && o_ready) n_state = S_SQ;
            S_SQ:   n_state = S_SUM;
            S_SUM:  n_state = r_zero ? S_IDLE : S_ROT;
            S_ROT:  if (r_step == 5'(CordicSteps - 1)) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= '0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_valid && i_ready) o_valid <= 1'b0;
            if (i_valid && o_ready) r_phase <= w_phase_nx;
            if ((r_state == S_SUM && r_zero) ||
                (r_state == S_ROT && r_step == 5'(CordicSteps - 1))) o_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (i_valid && o_ready) begin
                    r_work.first     <= i_first_of_frame;
                    r_work.ring      <= i_ring;
                    r_work.x         <= i_pos_x;
                    r_work.y         <= i_pos_y;
                    r_work.z         <= i_pos_z;
                    r_work.intensity <= i_intensity;
                    r_phase0 <= (w_phase_in == 8'd0);
                    r_zero   <= (i_pos_x == '0) && (i_pos_y == '0);
                    r_step   <= '0;
                    if (i_pos_x < 0) begin
                        if (i_pos_y >= 0) begin
                            r_cx <= CordicW'(i_pos_y);
                            r_cy <= -CordicW'(i_pos_x);
                            r_cz <= Deg90;
                        end else begin
                            r_cx <= -CordicW'(i_pos_y);
                            r_cy <= CordicW'(i_pos_x);
                            r_cz <= -Deg90;
                        end
                    end else begin
                        r_cx <= CordicW'(i_pos_x);
                        r_cy <= CordicW'(i_pos_y);
                        r_cz <= '0;
                    end
                end
            end
            S_SQ: begin
                r_sx <= 50'(r_work.x) * 50'(r_work.x);
                r_sy <= 50'(r_work.y) * 50'(r_work.y);
                r_sz <= 50'(r_work.z) * 50'(r_work.z);
                r_b2 <= 48'(i_blind) * 48'(i_blind);
            end
            S_SUM: begin
                r_work.keep <= r_phase0 && (w_r2 > 52'(r_b2));
                if (r_zero) r_work.yaw <= '0;
            end
            S_ROT: begin
                r_step <= r_step + 5'd1;
                if (r_cy >= 0) begin
                    r_cx <= r_cx + w_ys;
                    r_cy <= r_cy - w_xs;
                    r_cz <= r_cz + atan_lut(r_step);
                    r_work.yaw <= r_cz + atan_lut(r_step);
                end else begin
                    r_cx <= r_cx - w_ys;
                    r_cy <= r_cy + w_xs;
                    r_cz <= r_cz - atan_lut(r_step);
                    r_work.yaw <= r_cz - atan_lut(r_step);
                end
            end
            default: ;
        endcase
    end
endmodule

### hw/rtl/slpto_queue.sv
// Two-word queue between front and back.
// Depends on slpto_pkg.
module slpto_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  slpto_pkg::t_work i_work,
    output logic             o_valid,
    input  logic             i_ready,
    output slpto_pkg::t_work o_work
);
    import slpto_pkg::*;
    t_work r_mem [QDepth];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic w_push, w_pop;
    assign o_ready = r_cnt != 2'(QDepth);
    assign o_valid = r_cnt != 2'd0;
    assign o_work  = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= i_work;
    end
endmodule

### hw/rtl/slpto_back.sv
// Back: per-ring tables, offset scaling, wrap and output register.
// Depends on slpto_pkg.
module slpto_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  slpto_pkg::t_work   i_work,
    input  logic [15:0]        i_ms_deg,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_keep,
    output logic [19:0]        o_time_ofs,
    output logic signed [24:0] o_out_x,
    output logic signed [24:0] o_out_y,
    output logic signed [24:0] o_out_z,
    output logic [15:0]        o_out_intensity
);
    import slpto_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001, S_RD = 4'b0010, S_MUL = 4'b0100, S_FIN = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic [Rings-1:0] r_seen;
    logic signed [AngW-1:0] r_fyaw [Rings];
    logic [OfsW-1:0] r_lofs [Rings];
    logic signed [AngW-1:0] r_rd_yaw;
    logic [OfsW-1:0] r_rd_lofs;
    logic r_rd_seen;
    t_work r_w;
    logic [41:0] r_prod, r_turn;
    logic [AngW-1:0] w_diff;
    logic signed [AngW:0] w_d;
    logic [21:0] w_ofs, w_tot;
    logic [19:0] w_fin;
    logic w_in_tab;

    assign o_ready = r_state == S_IDLE;
    assign w_in_tab = 32'(r_w.ring) < Rings;

    always_comb begin
        w_d = (AngW+1)'(r_rd_yaw) - (AngW+1)'(r_w.yaw);
        if (r_w.yaw > r_rd_yaw) w_d = w_d + (AngW+1)'(Deg360);
        w_diff = w_d[AngW] ? '0 : w_d[AngW-1:0];
        w_ofs = 22'((r_prod + 42'(1 << 21)) >> 22);
        w_tot = 22'((r_turn + 42'(1 << 21)) >> 22);
        if (w_ofs < 22'(r_rd_lofs)) w_ofs = w_ofs + w_tot;
        if (!r_rd_seen || !w_in_tab) w_fin = '0;
        else if (w_ofs > 22'hFFFFF) w_fin = 20'hFFFFF;
        else w_fin = w_ofs[19:0];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_valid) n_state = S_RD;
            S_RD:   n_state = S_MUL;
            S_MUL:  n_state = S_FIN;
            S_FIN:  if (!o_valid || i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_seen  <= '0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE && i_valid && i_work.first) r_seen <= '0;
            if (r_state == S_FIN && (!o_valid || i_ready)) begin
                o_valid <= 1'b1;
                if (w_in_tab) r_seen[r_w.ring] <= 1'b1;
            end else if (o_valid && i_ready) begin
                o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_w       <= i_work;
            r_rd_seen <= r_seen[i_work.ring] && !i_work.first;
        end
        if (r_state == S_RD) begin
            r_rd_yaw  <= r_fyaw[r_w.ring];
            r_rd_lofs <= r_lofs[r_w.ring];
        end
        if (r_state == S_MUL) begin
            r_prod <= 42'(w_diff) * 42'(i_ms_deg);
            r_turn <= 42'(Deg360) * 42'(i_ms_deg);
        end
        if (r_state == S_FIN && (!o_valid || i_ready)) begin
            if (w_in_tab) begin
                r_lofs[r_w.ring] <= w_fin;
                if (!r_rd_seen) r_fyaw[r_w.ring] <= r_w.yaw;
            end
            o_keep          <= r_w.keep;
            o_time_ofs      <= w_fin;
            o_out_x         <= r_w.x;
            o_out_y         <= r_w.y;
            o_out_z         <= r_w.z;
            o_out_intensity <= r_w.intensity;
        end
    end
endmodule

### hw/rtl/slpto_checker.sv
// Port-level checks for the time offset unit, bound to the top level.
// Depends on spin_lidar_point_time_offset_unit_defines.svh.
`include "spin_lidar_point_time_offset_unit_defines.svh"
module slpto_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_keep,
    input logic [19:0] o_time_ofs
);
    `SLT_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready,
                    o_valid && $stable(o_time_ofs) && $stable(o_keep))
    `SLT_ASSERT_NXT(a_no_back2back, i_clk, i_rst_n, i_valid && o_ready, !o_ready)
    `SLT_ASSERT_IMP(a_out_known, i_clk, i_rst_n, o_valid,
                    !$isunknown({o_keep, o_time_ofs}))
endmodule

bind spin_lidar_point_time_offset_unit slpto_checker u_slpto_checker (
    .i_clk, .i_rst_n, .i_valid, .o_ready, .o_valid, .i_ready,
    .o_keep, .o_time_ofs
);
